// ===== design/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned TICK_W   = 32;
  localparam logic [TICK_W-1:0] NONE_DUE = 32'hffff_ffff;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_BIND    = 3'd2,
    CMD_ARM     = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_BAD     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ENT_FREE  = 2'd0,
    ENT_ALLOC = 2'd1,
    ENT_ARMED = 2'd2
  } ent_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_REPLY, S_BIND_RD, S_BIND_WR,
    S_UL_RD, S_UL_LH, S_UL_HDL, S_UL_WRD, S_UL_WCHK, S_UL_WR, S_UL_END,
    S_AR_RD, S_AR_WR, S_IN_START, S_IN_LINK, S_IN_DL, S_IN_CMP, S_IN_W1, S_IN_W2,
    S_EX_RD, S_EX_DL, S_EX_EMIT
  } fsm_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  handle;
    logic [3:0]  queue_id;
    logic [7:0]  event_data;
    logic [31:0] delay;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] entry;
    logic [1:0] status;
    logic [3:0] dest_queue;
    logic [7:0] dest_data;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [3:0]        queue;
    logic [7:0]        data;
    logic [TICK_W-1:0] deadline;
  } slot_t;

  typedef struct packed {
    logic                we;
    logic [HANDLE_W-1:0] idx;
    ent_e                st;
  } pool_req_t;

  typedef struct packed {
    ent_e                st;
    logic                found;
    logic [HANDLE_W-1:0] free_idx;
  } pool_rsp_t;

endpackage

// ===== design/stq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_if
// Valid/ready channels carrying command and result words.
// ----------------------------------------------------------------------------
interface stq_in_if;
  logic               valid;
  logic               ready;
  stq_pkg::in_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stq_out_if;
  logic               valid;
  logic               ready;
  stq_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Pool of timers on one tick count, armed entries kept in a deadline-sorted
// linked list.
// ----------------------------------------------------------------------------
// Commands enter on in_i (allocate, release, bind, arm, tick), one word at a
// time; results leave on out_o. Every command but tick gives one reply word.
// A tick gives one expiry word per due entry, in deadline order, or a single
// "nothing due" word; the last word of each command has last set.
// Links live in one RAM and deadline plus bound queue/byte in another, both
// with registered read data; all list work is read, modify, write back.
// Unlinking an armed entry (release or re-arm) walks the list from the head
// to its predecessor, and arm then inserts by walking the list and comparing
// deadlines, so both take longer the more entries are armed. A tick that
// expires entries removes them from the head of the list one after another.
// A new command is taken once the previous one has produced its last word
// into the output register; that register holds a word while out_o stalls,
// and the sequencer waits whenever it has a word to give and the register
// is still full. Reset frees all entries, empties the list and clears the
// tick count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stq_in_if.sink    in_i,
  stq_out_if.source out_o
);

  localparam int unsigned POOL = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
  localparam int unsigned IW   = $clog2(POOL);
  localparam int unsigned CW   = $clog2(POOL + 1);
  localparam int unsigned SW   = $bits(stq_pkg::slot_t);

  stq_pkg::fsm_e      state_q, state_d;
  stq_pkg::in_word_t  cmd_q, cmd_d;
  stq_pkg::out_word_t res_q, res_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [IW-1:0]      head_q, head_d, prev_q, prev_d, nxt_q, nxt_d, lh_q, lh_d;
  logic [CW-1:0]      cnt_q, cnt_d, k_q, k_d;
  logic [31:0]        tick_q, tick_d, earliest_q, earliest_d, dl_q, dl_d;
  stq_pkg::slot_t     ex_q, ex_d;

  logic               l_we, l_re;
  logic [IW-1:0]      l_waddr, l_raddr, l_wdata, l_rdata;
  logic               b_we, b_re;
  logic [IW-1:0]      b_waddr, b_raddr;
  stq_pkg::slot_t     b_wdata, b_rdata;

  stq_pkg::pool_req_t pool_req;
  stq_pkg::pool_rsp_t pool_rsp;

  logic               can_emit, hdl_ok, due;
  logic [IW-1:0]      idx;
  logic [31:0]        tick_inc;

  stq_ram #(.WIDTH(IW), .DEPTH(POOL)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  stq_ram #(.WIDTH(SW), .DEPTH(POOL)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  stq_pool #(.POOL(POOL)) u_pool (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (pool_req),
    .rd_idx_i (cmd_q.handle),
    .rsp_o    (pool_rsp)
  );

  assign in_i.ready    = (state_q == stq_pkg::S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign can_emit      = !out_valid_q || out_o.ready;
  assign idx           = cmd_q.handle[IW-1:0];
  assign hdl_ok        = ({1'b0, cmd_q.handle} < 5'(POOL)) &&
                         (pool_rsp.st != stq_pkg::ENT_FREE);
  assign tick_inc      = tick_q + 32'd1;
  assign due           = (cnt_q > CW'(1)) && (b_rdata.deadline <= tick_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      cnt_q       <= '0;
      tick_q      <= '0;
      earliest_q  <= stq_pkg::NONE_DUE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      earliest_q  <= earliest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    out_q  <= out_d;
    prev_q <= prev_d;
    nxt_q  <= nxt_d;
    lh_q   <= lh_d;
    k_q    <= k_d;
    dl_q   <= dl_d;
    ex_q   <= ex_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    head_d      = head_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    earliest_d  = earliest_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    lh_d        = lh_q;
    k_d         = k_q;
    dl_d        = dl_q;
    ex_d        = ex_q;
    l_we        = 1'b0;
    l_waddr     = idx;
    l_wdata     = head_q;
    l_re        = 1'b0;
    l_raddr     = idx;
    b_we        = 1'b0;
    b_waddr     = idx;
    b_wdata     = b_rdata;
    b_re        = 1'b0;
    b_raddr     = idx;
    pool_req    = '{we: 1'b0, idx: cmd_q.handle, st: stq_pkg::ENT_FREE};

    unique case (state_q)
      stq_pkg::S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.payload;
          state_d = stq_pkg::S_DECODE;
        end
      end

      stq_pkg::S_DECODE: begin
        res_d = '{kind: stq_pkg::KIND_REPLY, entry: cmd_q.handle,
                  status: stq_pkg::STAT_OK, dest_queue: '0, dest_data: '0, last: 1'b1};
        state_d = stq_pkg::S_REPLY;
        unique case (cmd_q.command)
          stq_pkg::CMD_ALLOC: begin
            if (pool_rsp.found) begin
              res_d.entry  = pool_rsp.free_idx;
              pool_req     = '{we: 1'b1, idx: pool_rsp.free_idx, st: stq_pkg::ENT_ALLOC};
            end else begin
              res_d.entry  = '0;
              res_d.status = stq_pkg::STAT_NO_FREE;
            end
          end
          stq_pkg::CMD_RELEASE: begin
            if (!hdl_ok) begin
              res_d.status = stq_pkg::STAT_BAD;
            end else if (pool_rsp.st == stq_pkg::ENT_ARMED) begin
              state_d = stq_pkg::S_UL_RD;
            end else begin
              pool_req = '{we: 1'b1, idx: cmd_q.handle, st: stq_pkg::ENT_FREE};
            end
          end
          stq_pkg::CMD_BIND: begin
            if (!hdl_ok) begin
              res_d.status = stq_pkg::STAT_BAD;
            end else begin
              state_d = stq_pkg::S_BIND_RD;
            end
          end
          stq_pkg::CMD_ARM: begin
            dl_d = tick_q + cmd_q.delay;
            if (!hdl_ok) begin
              res_d.status = stq_pkg::STAT_BAD;
            end else if (pool_rsp.st == stq_pkg::ENT_ARMED) begin
              state_d = stq_pkg::S_UL_RD;
            end else begin
              state_d = stq_pkg::S_AR_RD;
            end
          end
          stq_pkg::CMD_TICK: begin
            tick_d = tick_inc;
            if ((cnt_q != '0) && (earliest_q <= tick_inc)) begin
              state_d = stq_pkg::S_EX_RD;
            end else begin
              res_d.kind  = stq_pkg::KIND_IDLE;
              res_d.entry = '0;
            end
          end
          default: begin
            res_d.entry  = '0;
            res_d.status = stq_pkg::STAT_BAD;
          end
        endcase
      end

      stq_pkg::S_REPLY: begin
        if (can_emit) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = stq_pkg::S_IDLE;
        end
      end

      stq_pkg::S_BIND_RD: begin
        b_re    = 1'b1;
        state_d = stq_pkg::S_BIND_WR;
      end

      stq_pkg::S_BIND_WR: begin
        b_we    = 1'b1;
        b_wdata = '{queue: cmd_q.queue_id, data: cmd_q.event_data,
                    deadline: b_rdata.deadline};
        state_d = stq_pkg::S_REPLY;
      end

      stq_pkg::S_UL_RD: begin
        l_re    = 1'b1;
        state_d = stq_pkg::S_UL_LH;
      end

      stq_pkg::S_UL_LH: begin
        lh_d = l_rdata;
        if (head_q == idx) begin
          head_d = l_rdata;
          cnt_d  = cnt_q - CW'(1);
          if (cnt_q > CW'(1)) begin
            b_re    = 1'b1;
            b_raddr = l_rdata;
            state_d = stq_pkg::S_UL_HDL;
          end else begin
            earliest_d = stq_pkg::NONE_DUE;
            state_d    = stq_pkg::S_UL_END;
          end
        end else begin
          prev_d  = head_q;
          state_d = stq_pkg::S_UL_WRD;
        end
      end

      stq_pkg::S_UL_HDL: begin
        earliest_d = b_rdata.deadline;
        state_d    = stq_pkg::S_UL_END;
      end

      stq_pkg::S_UL_WRD: begin
        l_re    = 1'b1;
        l_raddr = prev_q;
        state_d = stq_pkg::S_UL_WCHK;
      end

      stq_pkg::S_UL_WCHK: begin
        if (l_rdata == idx) begin
          state_d = stq_pkg::S_UL_WR;
        end else begin
          prev_d  = l_rdata;
          state_d = stq_pkg::S_UL_WRD;
        end
      end

      stq_pkg::S_UL_WR: begin
        l_we    = 1'b1;
        l_waddr = prev_q;
        l_wdata = lh_q;
        cnt_d   = cnt_q - CW'(1);
        state_d = stq_pkg::S_UL_END;
      end

      stq_pkg::S_UL_END: begin
        if (cmd_q.command == stq_pkg::CMD_ARM) begin
          state_d = stq_pkg::S_AR_RD;
        end else begin
          pool_req = '{we: 1'b1, idx: cmd_q.handle, st: stq_pkg::ENT_FREE};
          state_d  = stq_pkg::S_REPLY;
        end
      end

      stq_pkg::S_AR_RD: begin
        b_re    = 1'b1;
        state_d = stq_pkg::S_AR_WR;
      end

      stq_pkg::S_AR_WR: begin
        b_we     = 1'b1;
        b_wdata  = '{queue: b_rdata.queue, data: b_rdata.data, deadline: dl_q};
        pool_req = '{we: 1'b1, idx: cmd_q.handle, st: stq_pkg::ENT_ARMED};
        state_d  = stq_pkg::S_IN_START;
      end

      stq_pkg::S_IN_START: begin
        if (cnt_q == '0) begin
          head_d     = idx;
          earliest_d = dl_q;
          cnt_d      = cnt_q + CW'(1);
          state_d    = stq_pkg::S_REPLY;
        end else if (dl_q <= earliest_q) begin
          l_we       = 1'b1;
          head_d     = idx;
          earliest_d = dl_q;
          cnt_d      = cnt_q + CW'(1);
          state_d    = stq_pkg::S_REPLY;
        end else begin
          prev_d  = head_q;
          k_d     = CW'(1);
          state_d = stq_pkg::S_IN_LINK;
        end
      end

      stq_pkg::S_IN_LINK: begin
        l_re    = 1'b1;
        l_raddr = prev_q;
        state_d = stq_pkg::S_IN_DL;
      end

      stq_pkg::S_IN_DL: begin
        nxt_d = l_rdata;
        if (k_q >= cnt_q) begin
          state_d = stq_pkg::S_IN_W1;
        end else begin
          b_re    = 1'b1;
          b_raddr = l_rdata;
          state_d = stq_pkg::S_IN_CMP;
        end
      end

      stq_pkg::S_IN_CMP: begin
        if (dl_q <= b_rdata.deadline) begin
          state_d = stq_pkg::S_IN_W1;
        end else begin
          prev_d  = nxt_q;
          k_d     = k_q + CW'(1);
          state_d = stq_pkg::S_IN_LINK;
        end
      end

      stq_pkg::S_IN_W1: begin
        l_we    = 1'b1;
        l_wdata = nxt_q;
        state_d = stq_pkg::S_IN_W2;
      end

      stq_pkg::S_IN_W2: begin
        l_we    = 1'b1;
        l_waddr = prev_q;
        l_wdata = idx;
        cnt_d   = cnt_q + CW'(1);
        state_d = stq_pkg::S_REPLY;
      end

      stq_pkg::S_EX_RD: begin
        l_re    = 1'b1;
        l_raddr = head_q;
        b_re    = 1'b1;
        b_raddr = head_q;
        state_d = stq_pkg::S_EX_DL;
      end

      stq_pkg::S_EX_DL: begin
        ex_d    = b_rdata;
        nxt_d   = l_rdata;
        b_re    = 1'b1;
        b_raddr = l_rdata;
        state_d = stq_pkg::S_EX_EMIT;
      end

      stq_pkg::S_EX_EMIT: begin
        if (can_emit) begin
          out_d = '{kind: stq_pkg::KIND_EXPIRY, entry: stq_pkg::HANDLE_W'(head_q),
                    status: stq_pkg::STAT_OK, dest_queue: ex_q.queue,
                    dest_data: ex_q.data, last: !due};
          out_valid_d = 1'b1;
          pool_req    = '{we: 1'b1, idx: stq_pkg::HANDLE_W'(head_q),
                          st: stq_pkg::ENT_ALLOC};
          head_d      = nxt_q;
          cnt_d       = cnt_q - CW'(1);
          earliest_d  = (cnt_q > CW'(1)) ? b_rdata.deadline : stq_pkg::NONE_DUE;
          state_d     = due ? stq_pkg::S_EX_RD : stq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = stq_pkg::S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(POOL))
    else $error("armed count exceeds pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (earliest_q == stq_pkg::NONE_DUE))
    else $error("empty list with a pending deadline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::S_EX_EMIT) |-> ((cnt_q != '0) && (earliest_q <= tick_q)))
    else $error("expiry of an entry that is not due");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stq_pkg::S_EX_EMIT && can_emit) |=> out_valid_q)
    else $error("expiry word lost");

endmodule

// ===== design/stq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stq_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pool
// Per-entry state flops (free, allocated, armed) and lowest-free search.
// ----------------------------------------------------------------------------
module stq_pool #(
  parameter int unsigned POOL = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stq_pkg::pool_req_t                  req_i,
  input  logic [stq_pkg::HANDLE_W-1:0]        rd_idx_i,
  output stq_pkg::pool_rsp_t                  rsp_o
);

  localparam int unsigned IW = $clog2(POOL);

  stq_pkg::ent_e st_q [POOL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL; i++) begin
        st_q[i] <= stq_pkg::ENT_FREE;
      end
    end else if (req_i.we) begin
      st_q[req_i.idx[IW-1:0]] <= req_i.st;
    end
  end

  always_comb begin
    rsp_o.st       = st_q[rd_idx_i[IW-1:0]];
    rsp_o.found    = 1'b0;
    rsp_o.free_idx = '0;
    for (int i = POOL - 1; i >= 0; i--) begin
      if (st_q[i] == stq_pkg::ENT_FREE) begin
        rsp_o.found    = 1'b1;
        rsp_o.free_idx = stq_pkg::HANDLE_W'(i);
      end
    end
  end

endmodule
